>>> rtl/pdbr_pkg.sv
package pdbr_pkg;

	// default coordinate width (signed Q15.8)
	localparam int COORD_BITS_DEF = 24;

	// control from the stream side into the core
	typedef struct packed {
		logic start;     // input transaction accepted this cycle
		logic out_free;  // output register can take a result this cycle
	} pdbr_ctl_t;

	// status from the core back to the stream side
	typedef struct packed {
		logic busy;      // an item is being worked on
		logic done;      // root is valid this cycle, output register loads it
	} pdbr_stat_t;

endpackage

>>> rtl/pdbr_core.sv
// Distance core: one multiplier squares the two axis differences in turn,
// then one shared subtract/compare unit resolves one root bit per cycle.
module pdbr_core #(
	parameter int COORD_BITS = pdbr_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pdbr_pkg::pdbr_ctl_t     ctl,
	input  logic [COORD_BITS-1:0]   first_x,
	input  logic [COORD_BITS-1:0]   first_y,
	input  logic [COORD_BITS-1:0]   second_x,
	input  logic [COORD_BITS-1:0]   second_y,
	output pdbr_pkg::pdbr_stat_t    stat,
	output logic [COORD_BITS:0]     root
);

	localparam int DW = COORD_BITS + 1;          // difference and root width
	localparam int RW = 2 * COORD_BITS + 2;      // square, remainder width
	localparam int KW = $clog2(COORD_BITS + 1);  // root bit index width

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQX  = 3'd1;
	localparam logic [2:0] ST_SQY  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_ROOT = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]     state_q;
	logic [KW-1:0]  k_q;
	logic [DW-1:0]  dx_q;
	logic [DW-1:0]  dy_q;
	logic [RW-1:0]  prod_q;
	logic [RW-1:0]  rem_q;
	logic [RW-1:0]  y_q;
	logic [RW-1:0]  t_q;

	logic signed [DW-1:0] diff_x;
	logic signed [DW-1:0] diff_y;
	logic [DW-1:0]        abs_x;
	logic [DW-1:0]        abs_y;
	logic [DW-1:0]        mul_a;
	logic [RW-1:0]        mul_p;
	logic [RW-1:0]        cand;
	logic [RW:0]          sub;
	logic                 bit_set;

	// axis differences, sign extended one bit, then magnitude
	always_comb begin
		diff_x = DW'($signed(second_x)) - DW'($signed(first_x));
		diff_y = DW'($signed(second_y)) - DW'($signed(first_y));
		abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
		abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
	end

	// shared squarer
	assign mul_a = (state_q == ST_SQX) ? dx_q : dy_q;
	assign mul_p = RW'(mul_a) * RW'(mul_a);

	// shared subtract/compare: remainder against (root << (k+1)) + 4^k
	assign cand    = y_q + t_q;
	assign sub     = {1'b0, rem_q} - {1'b0, cand};
	assign bit_set = !sub[RW];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (ctl.start) state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY:  state_q <= ST_ADD;
				ST_ADD: begin
					state_q <= ST_ROOT;
					k_q     <= KW'(COORD_BITS);
				end
				ST_ROOT: begin
					if (k_q == '0) state_q <= ST_DONE;
					else k_q <= k_q - 1'b1;
				end
				ST_DONE: if (ctl.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					dx_q <= abs_x;
					dy_q <= abs_y;
				end
			end
			ST_SQX: rem_q  <= mul_p;
			ST_SQY: prod_q <= mul_p;
			ST_ADD: begin
				rem_q <= rem_q + prod_q;
				y_q   <= '0;
				t_q   <= RW'(1) << (2 * COORD_BITS);
			end
			ST_ROOT: begin
				if (bit_set) begin
					rem_q <= sub[RW-1:0];
					y_q   <= (y_q >> 1) + t_q;
				end else begin
					y_q   <= y_q >> 1;
				end
				t_q <= t_q >> 2;
			end
			default: ;
		endcase
	end

	assign stat.busy = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE) && ctl.out_free;
	assign root      = y_q[DW-1:0];

	// root bit index never runs past the top bit
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> (k_q <= KW'(COORD_BITS)))
		else $error("root bit index out of range");

	// finished root fits the distance field
	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> ((y_q >> DW) == '0))
		else $error("root wider than distance field");

endmodule

>>> rtl/point_distance_bisection_root.sv
// Flow: the squarer squares the two axis differences in turn, the squares are added, then
// the one-bit-per-cycle root loop of the shared subtract/compare unit resolves the root,
// which is handed to the output register. The core takes no new item until the root is
// handed to the output register.
// Reset: arst_n clears the sequencer and the output valid; no result is pending after.
module point_distance_bisection_root #(
	parameter int COORD_BITS = pdbr_pkg::COORD_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       s_axis_tvalid,
	output logic                                       s_axis_tready,
	// first_x, first_y, second_x, second_y (COORD_BITS each), zero pad
	input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                                       m_axis_tvalid,
	input  logic                                       m_axis_tready,
	// distance (COORD_BITS+1), zero pad
	output logic [((COORD_BITS + 8) / 8) * 8 - 1:0]     m_axis_tdata
);

	localparam int DW        = COORD_BITS + 1;

	pdbr_pkg::pdbr_ctl_t  ctl;
	pdbr_pkg::pdbr_stat_t stat;
	logic [DW-1:0]        root;
	logic [DW-1:0]        dist_q;
	logic                 m_tvalid_q;
	logic                 s_xfer;

	assign s_axis_tready = !stat.busy;
	assign s_xfer        = s_axis_tvalid && s_axis_tready;

	assign ctl.start    = s_xfer;
	assign ctl.out_free = !m_tvalid_q || m_axis_tready;

	pdbr_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.first_x  (s_axis_tdata[0*COORD_BITS +: COORD_BITS]),
		.first_y  (s_axis_tdata[1*COORD_BITS +: COORD_BITS]),
		.second_x (s_axis_tdata[2*COORD_BITS +: COORD_BITS]),
		.second_y (s_axis_tdata[3*COORD_BITS +: COORD_BITS]),
		.stat     (stat),
		.root     (root)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (stat.done) m_tvalid_q <= 1'b1;
			else if (m_axis_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) dist_q <= root;
	end

	assign m_axis_tvalid = m_tvalid_q;

	always_comb begin
		m_axis_tdata           = '0;
		m_axis_tdata[DW-1:0]   = dist_q;
	end

	// a finished root never overwrites a result still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> (!m_tvalid_q || m_axis_tready))
		else $error("result overwritten in output register");

	// an accepted transaction starts the core
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_xfer |=> stat.busy)
		else $error("core not busy after input transaction");

	// output valid only rises from a finished root
	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(stat.done))
		else $error("output valid without finished root");

endmodule

>>> dv/tb.sv
module tb;

	localparam int CW     = pdbr_pkg::COORD_BITS_DEF;
	localparam int DIST_W = CW + 1;
	localparam int S_W    = ((4 * CW + 7) / 8) * 8;
	localparam int M_W    = ((DIST_W + 7) / 8) * 8;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 40;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [DIST_W-1:0]    dist_t;

	localparam coord_t COORD_MIN = coord_t'(-(64'sd1 <<< (CW - 1)));
	localparam coord_t COORD_MAX = coord_t'((64'sd1 <<< (CW - 1)) - 1);

	// Expected distances for accepted point pairs, oldest first
	class distance_scoreboard;
		dist_t pending_distances[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		// floor root of the summed squares, built one result bit at a time
		function dist_t point_distance(logic [S_W-1:0] pts);
			longint dx;
			longint dy;
			longint unsigned sum_sq;
			longint unsigned root;
			longint unsigned trial;
			dx = longint'($signed(pts[2*CW +: CW])) - longint'($signed(pts[0 +: CW]));
			dy = longint'($signed(pts[3*CW +: CW])) - longint'($signed(pts[CW +: CW]));
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			sum_sq = longint'(dx * dx) + longint'(dy * dy);
			root = 0;
			for (int b = DIST_W - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= sum_sq) root = trial;
			end
			return root[DIST_W-1:0];
		endfunction

		function void note_points(logic [S_W-1:0] pts);
			pending_distances.push_back(point_distance(pts));
		endfunction

		function void check_distance(logic [M_W-1:0] data);
			dist_t want;
			if (pending_distances.size() == 0) begin
				$display("%0t unexpected result: expected none, actual distance %0d",
					$time, data[DIST_W-1:0]);
				errors++;
				return;
			end
			want = pending_distances.pop_front();
			if (data[DIST_W-1:0] !== want) begin
				$display("%0t distance mismatch: expected %0d, actual %0d",
					$time, want, data[DIST_W-1:0]);
				errors++;
			end
		endfunction

		function int pending_count();
			return pending_distances.size();
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           s_axis_tvalid;
	logic           s_axis_tready;
	// first_x, first_y, second_x, second_y
	logic [S_W-1:0] s_axis_tdata;
	logic           m_axis_tvalid;
	logic           m_axis_tready;
	// distance, zero pad
	logic [M_W-1:0] m_axis_tdata;

	distance_scoreboard sb;
	int tx_idle_pct;
	int rx_idle_pct;
	bit rx_hold_req;
	int quiet_cycles;

	point_distance_bisection_root #(
		.COORD_BITS(CW)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #6 clk = ~clk;

	// offer one point pair, with random idle cycles ahead of it
	task automatic send_points(input coord_t ax, input coord_t ay,
		input coord_t bx, input coord_t by);
		if ($urandom_range(99) < tx_idle_pct) begin
			do begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
			end while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {by, bx, ay, ax};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// random pair: full range, close points, extreme values or small values
	task automatic send_random_points();
		coord_t c[4];
		int unsigned kind;
		kind = $urandom_range(3);
		for (int i = 0; i < 4; i++) begin
			case (kind)
				0: begin
					c[i] = coord_t'($urandom);
				end
				1: begin
					if (i < 2) c[i] = coord_t'($urandom);
					else c[i] = c[i-2] + coord_t'($signed($urandom_range(2048)) - 1024);
				end
				2: begin
					case ($urandom_range(5))
						0: c[i] = COORD_MIN;
						1: c[i] = COORD_MAX;
						2: c[i] = '0;
						3: c[i] = '1;
						4: c[i] = coord_t'(1);
						default: c[i] = coord_t'($urandom);
					endcase
				end
				default: begin
					c[i] = coord_t'($signed($urandom_range(4095)) - 2048);
				end
			endcase
		end
		send_points(c[0], c[1], c[2], c[3]);
	endtask

	task automatic wait_all_distances();
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	// output side: random stall, or one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) sb.note_points(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) sb.check_distance(m_axis_tdata);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
				$display("Regression FAIL");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		sb            = new();
		clk           = 1'b0;
		tx_idle_pct   = 29;
		rx_idle_pct   = 79;
		rx_hold_req   = 1'b0;
		quiet_cycles  = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		m_axis_tready <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: equal points, unit steps, exact root, extreme corners
		send_points('0, '0, '0, '0);
		send_points(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
		send_points(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
		send_points('0, '0, coord_t'(1), '0);
		send_points('0, '0, coord_t'(1), coord_t'(1));
		send_points('0, '0, coord_t'(2), '0);
		send_points('0, '0, coord_t'(3), coord_t'(3));
		send_points('0, '0, coord_t'(768), coord_t'(1024));
		send_points(coord_t'(1024), coord_t'(768), '0, '0);
		send_points('1, '1, '0, '0);
		send_points(COORD_MIN, '0, COORD_MAX, '0);
		send_points('0, COORD_MAX, '0, COORD_MIN);
		send_points(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
		send_points(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
		send_points(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
		send_points(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
		send_points(COORD_MAX, '0, COORD_MIN, '1);
		repeat (120) send_random_points();

		// sender pauses until the pipe is empty
		s_axis_tvalid <= 1'b0;
		wait_all_distances();

		tx_idle_pct = 79;
		rx_idle_pct = 29;
		repeat (130) send_random_points();

		// no idling, with one long output hold-off while items keep coming
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b1;
		repeat (140) send_random_points();
		s_axis_tvalid <= 1'b0;

		wait_all_distances();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_count() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> point_distance_bisection_root.f
rtl/pdbr_pkg.sv
rtl/pdbr_core.sv
rtl/point_distance_bisection_root.sv
dv/tb.sv
